// ===== hw/rtl/icmp_pkg.sv =====
// Shared types and constants for the ice maker compressor and pump controller.
`timescale 1ns / 1ps

package icmp_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int NOW_BITS          = 32;
    localparam int CUR_BITS          = 16;
    localparam int CFG_DATA_BITS     = 32;
    localparam int CFG_IDX_BITS      = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_PUMP_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COOLDOWN      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CURRENT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRACE         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEFROST_LEN   = 3'd4;

    localparam logic [31:0] PUMP_TIMEOUT_RESET  = 32'd120000;
    localparam logic [31:0] COOLDOWN_RESET      = 32'd300000;
    localparam logic [15:0] CURRENT_LIMIT_RESET = 16'd500;
    localparam logic [31:0] GRACE_RESET         = 32'd15000;
    localparam logic [31:0] DEFROST_LEN_RESET   = 32'd600000;
    localparam logic [63:0] COOL_STOP_RESET     = 64'd300001;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_HALTED   = 2'd1,
        ST_NO_WATER = 2'd2,
        ST_COOLDOWN = 2'd3
    } status_t;

    typedef struct packed {
        logic pump_running;
        logic wait_reset;
        logic in_defrost;
        logic cooling_running;
    } flags_t;

    typedef struct packed {
        logic [31:0] pump_timeout_ms;
        logic [31:0] cooldown_ms;
        logic [15:0] current_limit_ma;
        logic [31:0] grace_ms;
        logic [31:0] defrost_length_ms;
    } cfg_t;

endpackage

// ===== hw/rtl/icmp_if.sv =====
// Valid/ready channel interfaces for control ticks, results and register writes.
`timescale 1ns / 1ps

interface icmp_item_if;
    logic                          valid;
    logic                          ready;
    logic [icmp_pkg::NOW_BITS-1:0] now_ms;
    logic                          power_on;
    logic                          tank_full;
    logic                          tank_empty;
    logic                          bin_present;
    logic [icmp_pkg::CUR_BITS-1:0] current_ma;

    modport source (
        output valid, now_ms, power_on, tank_full, tank_empty, bin_present, current_ma,
        input  ready
    );
    modport sink (
        input  valid, now_ms, power_on, tank_full, tank_empty, bin_present, current_ma,
        output ready
    );
endinterface

interface icmp_result_if;
    logic       valid;
    logic       ready;
    logic       pump_drive;
    logic       cooling_drive;
    logic [1:0] tick_status;
    logic       defrost_active;
    logic       reset_wait;

    modport source (
        output valid, pump_drive, cooling_drive, tick_status, defrost_active, reset_wait,
        input  ready
    );
    modport sink (
        input  valid, pump_drive, cooling_drive, tick_status, defrost_active, reset_wait,
        output ready
    );
endinterface

interface icmp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [icmp_pkg::CFG_IDX_BITS-1:0]  index;
    logic [icmp_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/icmp_rules.sv =====
// Interlock rule evaluation for one tick: next flags, timestamps and status.
`timescale 1ns / 1ps

module icmp_rules #(
    parameter int TIME_BITS = icmp_pkg::TIME_BITS_DEFAULT
) (
    input  icmp_pkg::flags_t                flags,
    input  logic [TIME_BITS-1:0]            pump_start,
    input  logic [TIME_BITS-1:0]            cool_stop,
    input  logic [TIME_BITS-1:0]            cool_start,
    input  logic [TIME_BITS-1:0]            defrost_start,
    input  icmp_pkg::cfg_t                  cfg,
    input  logic [TIME_BITS-1:0]            now,
    input  logic                            power_on,
    input  logic                            tank_full,
    input  logic                            tank_empty,
    input  logic                            bin_present,
    input  logic [icmp_pkg::CUR_BITS-1:0]   current_ma,
    output icmp_pkg::flags_t                flags_next,
    output logic [TIME_BITS-1:0]            pump_start_next,
    output logic [TIME_BITS-1:0]            cool_stop_next,
    output logic [TIME_BITS-1:0]            cool_start_next,
    output logic [TIME_BITS-1:0]            defrost_start_next,
    output icmp_pkg::status_t               status
);

    localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [TIME_BITS-1:0] el_pump;
    logic [TIME_BITS-1:0] el_stop;
    logic [TIME_BITS-1:0] el_start;
    logic [TIME_BITS-1:0] el_defrost;
    logic                 halt;
    logic                 pump_expired;
    logic                 cooldown_wait;
    logic                 defrost_done;
    logic                 overcurrent;
    logic                 pump_on;

    // all differences wrap at the time width
    assign el_pump    = now - pump_start;
    assign el_stop    = now - cool_stop;
    assign el_start   = now - cool_start;
    assign el_defrost = now - defrost_start;

    assign halt          = !power_on || flags.wait_reset || flags.in_defrost;
    assign pump_expired  = flags.pump_running &&
                           (CMP_BITS'(el_pump) > CMP_BITS'(cfg.pump_timeout_ms));
    assign cooldown_wait = !flags.cooling_running &&
                           (CMP_BITS'(el_stop) < CMP_BITS'(cfg.cooldown_ms));
    assign defrost_done  = CMP_BITS'(el_defrost) > CMP_BITS'(cfg.defrost_length_ms);
    // a fresh start has zero elapsed time, so only an already running compressor trips
    assign overcurrent   = flags.cooling_running && (current_ma >= cfg.current_limit_ma) &&
                           (CMP_BITS'(el_start) > CMP_BITS'(cfg.grace_ms));
    assign pump_on       = flags.pump_running || tank_empty;

    always_comb
    begin
        flags_next         = flags;
        pump_start_next    = pump_start;
        cool_stop_next     = cool_stop;
        cool_start_next    = cool_start;
        defrost_start_next = defrost_start;
        status             = icmp_pkg::ST_RUNNING;
        priority if (halt)
        begin
            status = icmp_pkg::ST_HALTED;
            if (flags.cooling_running)
            begin
                cool_stop_next = now;
            end
            flags_next.cooling_running = 1'b0;
            flags_next.pump_running    = 1'b0;
            if (!bin_present)
            begin
                flags_next.wait_reset = 1'b0;
            end
            if (defrost_done)
            begin
                flags_next.in_defrost = 1'b0;
            end
        end
        else if (pump_expired)
        begin
            status                = icmp_pkg::ST_NO_WATER;
            flags_next.wait_reset = 1'b1;
        end
        else
        begin
            if (tank_empty && !flags.pump_running)
            begin
                pump_start_next = now;
            end
            flags_next.pump_running = pump_on && !tank_full;
            if (cooldown_wait)
            begin
                status = icmp_pkg::ST_COOLDOWN;
            end
            else
            begin
                if (!flags.cooling_running)
                begin
                    cool_start_next = now;
                end
                flags_next.cooling_running = 1'b1;
                if (overcurrent)
                begin
                    flags_next.in_defrost = 1'b1;
                    defrost_start_next    = now;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/ice_maker_compressor_pump_controller.sv =====
// Path: a transferred tick waits in the input register, then moves into the result register.
// Throughput: one tick per cycle while results are taken; input ready follows result ready,
// and the state registers update once per tick as it moves into the result register.
// Reset (rst_n low, asynchronous): channels empty and flags cleared, with the drive outputs
// not reset; compressor stop time 300001, other times 0, registers at their default values.
`timescale 1ns / 1ps

module ice_maker_compressor_pump_controller #(
    parameter int TIME_BITS = icmp_pkg::TIME_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    icmp_cfg_if.sink             cfg,
    icmp_item_if.sink            item,
    icmp_result_if.source        result
);

    localparam logic [TIME_BITS-1:0] COOL_STOP_INIT = TIME_BITS'(icmp_pkg::COOL_STOP_RESET);

    icmp_pkg::cfg_t cfg_reg;
    icmp_pkg::cfg_t cfg_next;

    logic                          s1_valid_reg;
    logic [TIME_BITS-1:0]          s1_now_reg;
    logic                          s1_power_reg;
    logic                          s1_full_reg;
    logic                          s1_empty_reg;
    logic                          s1_bin_reg;
    logic [icmp_pkg::CUR_BITS-1:0] s1_cur_reg;

    icmp_pkg::flags_t     flags_reg;
    icmp_pkg::flags_t     flags_next;
    logic [TIME_BITS-1:0] pump_start_reg;
    logic [TIME_BITS-1:0] pump_start_next;
    logic [TIME_BITS-1:0] cool_stop_reg;
    logic [TIME_BITS-1:0] cool_stop_next;
    logic [TIME_BITS-1:0] cool_start_reg;
    logic [TIME_BITS-1:0] cool_start_next;
    logic [TIME_BITS-1:0] defrost_start_reg;
    logic [TIME_BITS-1:0] defrost_start_next;
    icmp_pkg::status_t    status_next;

    logic                 out_valid_reg;
    icmp_pkg::flags_t     out_flags_reg;
    icmp_pkg::status_t    out_status_reg;

    logic advance;
    logic item_xfer;

    // ---------------- configuration registers ----------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                icmp_pkg::REG_PUMP_TIMEOUT:  cfg_next.pump_timeout_ms   = cfg.data;
                icmp_pkg::REG_COOLDOWN:      cfg_next.cooldown_ms       = cfg.data;
                icmp_pkg::REG_CURRENT_LIMIT: cfg_next.current_limit_ma  = cfg.data[15:0];
                icmp_pkg::REG_GRACE:         cfg_next.grace_ms          = cfg.data;
                icmp_pkg::REG_DEFROST_LEN:   cfg_next.defrost_length_ms = cfg.data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pump_timeout_ms   <= icmp_pkg::PUMP_TIMEOUT_RESET;
            cfg_reg.cooldown_ms       <= icmp_pkg::COOLDOWN_RESET;
            cfg_reg.current_limit_ma  <= icmp_pkg::CURRENT_LIMIT_RESET;
            cfg_reg.grace_ms          <= icmp_pkg::GRACE_RESET;
            cfg_reg.defrost_length_ms <= icmp_pkg::DEFROST_LEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- handshake ----------------
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign item_xfer  = item.valid && item.ready;

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            s1_now_reg   <= TIME_BITS'(item.now_ms);
            s1_power_reg <= item.power_on;
            s1_full_reg  <= item.tank_full;
            s1_empty_reg <= item.tank_empty;
            s1_bin_reg   <= item.bin_present;
            s1_cur_reg   <= item.current_ma;
        end
    end

    // ---------------- rules ----------------
    icmp_rules #(
        .TIME_BITS (TIME_BITS)
    ) u_rules (
        .flags              (flags_reg),
        .pump_start         (pump_start_reg),
        .cool_stop          (cool_stop_reg),
        .cool_start         (cool_start_reg),
        .defrost_start      (defrost_start_reg),
        .cfg                (cfg_reg),
        .now                (s1_now_reg),
        .power_on           (s1_power_reg),
        .tank_full          (s1_full_reg),
        .tank_empty         (s1_empty_reg),
        .bin_present        (s1_bin_reg),
        .current_ma         (s1_cur_reg),
        .flags_next         (flags_next),
        .pump_start_next    (pump_start_next),
        .cool_stop_next     (cool_stop_next),
        .cool_start_next    (cool_start_next),
        .defrost_start_next (defrost_start_next),
        .status             (status_next)
    );

    // ---------------- controller state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg         <= '0;
            pump_start_reg    <= '0;
            cool_stop_reg     <= COOL_STOP_INIT;
            cool_start_reg    <= '0;
            defrost_start_reg <= '0;
        end
        else if (advance)
        begin
            flags_reg         <= flags_next;
            pump_start_reg    <= pump_start_next;
            cool_stop_reg     <= cool_stop_next;
            cool_start_reg    <= cool_start_next;
            defrost_start_reg <= defrost_start_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_flags_reg  <= flags_next;
            out_status_reg <= status_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.pump_drive     = out_flags_reg.pump_running;
    assign result.cooling_drive  = out_flags_reg.cooling_running;
    assign result.tick_status    = 2'(out_status_reg);
    assign result.defrost_active = out_flags_reg.in_defrost;
    assign result.reset_wait     = out_flags_reg.wait_reset;

`ifndef ASSERT_OFF
    a_halt_drives_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == icmp_pkg::ST_HALTED)
        |-> (!out_flags_reg.pump_running && !out_flags_reg.cooling_running))
        else $error("halt tick left a drive on");

    a_cooldown_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == icmp_pkg::ST_COOLDOWN)
        |-> !out_flags_reg.cooling_running)
        else $error("cooldown tick with compressor running");

    a_wait_from_fault: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flags_reg.wait_reset)
        |-> (out_valid_reg && out_status_reg == icmp_pkg::ST_NO_WATER))
        else $error("reset wait set without a water fault");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg) && $stable(cool_stop_reg))
        else $error("controller state moved without a tick");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("input stalled with empty result register");
`endif

endmodule
